@@ rtl/core/mtbt_pkg.sv @@
package mtbt_pkg;

  // Field widths
  localparam int KIND_W    = 3;
  localparam int SLOT_W    = 10;
  localparam int AMT_W     = 16;
  localparam int STAT_W    = 3;

  // The in-use bitmap is kept as rows of ROW_W bits
  localparam int ROW_W     = 32;
  localparam int ROW_BIT_W = 5;

  localparam int DEF_NUM_BUCKETS = 1024;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_CREATE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FETCH   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RETURN  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DESTROY = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK    = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_SIZE  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_TOKENS = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNUSED    = 3'd4;

  // Read address source
  localparam logic ADDR_IN  = 1'b0;
  localparam logic ADDR_CNT = 1'b1;

  // Result register source
  localparam logic [1:0] RES_CREATE = 2'd0;
  localparam logic [1:0] RES_FULL   = 2'd1;
  localparam logic [1:0] RES_SINGLE = 2'd2;
  localparam logic [1:0] RES_TICK   = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [AMT_W-1:0]  amount;
    logic [AMT_W-1:0]  fill_rate;
    logic [AMT_W-1:0]  burst_limit;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_out;
    logic [AMT_W-1:0]  granted;
    logic [AMT_W-1:0]  tokens_left;
  } out_t;

  typedef struct packed {
    logic [AMT_W-1:0] rate;
    logic [AMT_W-1:0] burst;
    logic [AMT_W-1:0] tokens;
  } bkt_t;

  typedef struct packed {
    logic       req_ld;
    logic       rd_en;
    logic       addr_sel;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       cnt_row;
    logic       clr_wr;
    logic       tick_wr;
    logic       cr_wr;
    logic       sg_wr;
    logic       res_ld;
    logic [1:0] res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic row_free;
    logic last_row;
    logic last_slot;
    logic cnt_last_row;
  } dp_sts_t;

endpackage

@@ rtl/core/mtbt_ctrl.sv @@
module mtbt_ctrl import mtbt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_ready,
  input  dp_sts_t           sts,
  output dp_cmd_t           cmd
);

  localparam logic [2:0] S_CLEAR     = 3'd0;
  localparam logic [2:0] S_IDLE      = 3'd1;
  localparam logic [2:0] S_SCAN      = 3'd2;
  localparam logic [2:0] S_CR_WR     = 3'd3;
  localparam logic [2:0] S_FULL      = 3'd4;
  localparam logic [2:0] S_SG_WB     = 3'd5;
  localparam logic [2:0] S_TICK      = 3'd6;
  localparam logic [2:0] S_TICK_DONE = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       pipe_v_r, pipe_v_nxt;  // read data of last cycle belongs to the walk

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    pipe_v_nxt = pipe_v_r;
    in_ready   = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.cnt_row = 1'b1;
        if (sts.cnt_last_row) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.req_ld = 1'b1;
          unique case (in_kind) inside
            KIND_CREATE: begin
              cmd.cnt_clr = 1'b1;
              pipe_v_nxt  = 1'b0;
              state_nxt   = S_SCAN;
            end
            KIND_FETCH, KIND_RETURN, KIND_DESTROY: begin
              cmd.rd_en    = 1'b1;
              cmd.addr_sel = ADDR_IN;
              state_nxt    = S_SG_WB;
            end
            KIND_TICK: begin
              cmd.cnt_clr = 1'b1;
              pipe_v_nxt  = 1'b0;
              state_nxt   = S_TICK;
            end
            default: ;  // unknown kinds are dropped
          endcase
        end
      end
      S_SCAN: begin
        if (pipe_v_r && sts.row_free) begin
          state_nxt = S_CR_WR;
        end else if (pipe_v_r && sts.last_row) begin
          state_nxt = S_FULL;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.addr_sel = ADDR_CNT;
          cmd.cnt_inc  = 1'b1;
          cmd.cnt_row  = 1'b1;
          pipe_v_nxt   = 1'b1;
        end
      end
      S_CR_WR: begin
        if (sts.out_free) begin
          cmd.cr_wr   = 1'b1;
          cmd.res_ld  = 1'b1;
          cmd.res_sel = RES_CREATE;
          state_nxt   = S_IDLE;
        end
      end
      S_FULL: begin
        if (sts.out_free) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = RES_FULL;
          state_nxt   = S_IDLE;
        end
      end
      S_SG_WB: begin
        if (sts.out_free) begin
          cmd.sg_wr   = 1'b1;
          cmd.res_ld  = 1'b1;
          cmd.res_sel = RES_SINGLE;
          state_nxt   = S_IDLE;
        end
      end
      S_TICK: begin
        cmd.tick_wr = pipe_v_r;
        if (pipe_v_r && sts.last_slot) begin
          state_nxt = S_TICK_DONE;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.addr_sel = ADDR_CNT;
          cmd.cnt_inc  = 1'b1;
          pipe_v_nxt   = 1'b1;
        end
      end
      S_TICK_DONE: begin
        if (sts.out_free) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = RES_TICK;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      pipe_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pipe_v_r <= pipe_v_nxt;
    end
  end

  // table writes only happen together with a result load into a free slot
  a_wr_with_res: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sg_wr || cmd.cr_wr) |-> (cmd.res_ld && sts.out_free))
    else $error("table write without result load");

  // a tick write-back always follows a walk read
  a_tick_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick_wr |-> $past(cmd.rd_en))
    else $error("tick write-back without prior read");

  // nothing is accepted while the bitmap is being cleared
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("accept during clear pass");

endmodule

@@ rtl/core/mtbt_dp.sv @@
module mtbt_dp import mtbt_pkg::*; #(
  parameter int NUM_BUCKETS = DEF_NUM_BUCKETS
) (
  input  logic    clk,
  input  logic    rst_n,
  input  in_t     in_data,
  input  dp_cmd_t cmd,
  output dp_sts_t sts,
  output logic    out_valid,
  input  logic    out_ready,
  output out_t    out_data
);

  localparam int NUM_ROWS   = (NUM_BUCKETS + ROW_W - 1) / ROW_W;
  localparam int ROW_IDX_W  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int ROWS_DEPTH = 1 << ROW_IDX_W;
  localparam int IDX_W      = ROW_IDX_W + ROW_BIT_W;
  localparam int DATA_DEPTH = 1 << IDX_W;
  localparam logic [31:0] NUM_BKT_U = 32'(NUM_BUCKETS);
  localparam logic [31:0] FULL_ROWS = 32'(NUM_BUCKETS / ROW_W);
  localparam int TAIL = NUM_BUCKETS % ROW_W;
  localparam logic [ROW_W-1:0] TAIL_MASK = ROW_W'((64'd1 << TAIL) - 64'd1);

  bkt_t             data_mem [DATA_DEPTH];
  logic [ROW_W-1:0] row_mem  [ROWS_DEPTH];

  in_t              req_r;
  bkt_t             data_rd_r;
  logic [ROW_W-1:0] row_rd_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  out_t             out_data_r;
  logic             out_valid_r;

  logic [IDX_W-1:0]     rd_addr;
  logic [ROW_IDX_W-1:0] s1_row;
  logic [ROW_BIT_W-1:0] s1_bit;
  logic                 bit_in_use;
  logic [ROW_W-1:0]     row_mask, free_mask;
  logic [ROW_BIT_W-1:0] free_bit;
  logic [IDX_W-1:0]     cr_idx;
  logic [AMT_W:0]       tick_sum, ret_sum;
  logic [AMT_W-1:0]     tick_new, ret_new, fetch_n, tok;
  logic                 slot_ok;

  logic [STAT_W-1:0] sg_status;
  logic [AMT_W-1:0]  sg_granted, sg_left, sg_tokens;
  logic              sg_data_we, sg_row_we;

  logic                 data_we, row_we;
  logic [IDX_W-1:0]     data_waddr;
  bkt_t                 data_wdata;
  logic [ROW_IDX_W-1:0] row_waddr;
  logic [ROW_W-1:0]     row_wdata;
  out_t                 res_val;

  assign rd_addr = (cmd.addr_sel == ADDR_IN) ? IDX_W'(in_data.slot) : cnt_r;

  // walk counter: +1 per slot for tick, +1 row for scan and clear
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      if (cmd.cnt_row) begin
        cnt_nxt = {cnt_r[IDX_W-1:ROW_BIT_W] + ROW_IDX_W'(1), cnt_r[ROW_BIT_W-1:0]};
      end else begin
        cnt_nxt = cnt_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_ld) begin
      req_r <= in_data;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      data_rd_r <= data_mem[rd_addr];
      row_rd_r  <= row_mem[rd_addr[IDX_W-1:ROW_BIT_W]];
      s1_idx_r  <= rd_addr;
    end
  end

  assign s1_row     = s1_idx_r[IDX_W-1:ROW_BIT_W];
  assign s1_bit     = s1_idx_r[ROW_BIT_W-1:0];
  assign bit_in_use = row_rd_r[s1_bit];
  assign tok        = data_rd_r.tokens;

  // lowest free slot in the row just read; slots past the table count as taken
  assign row_mask  = (32'(s1_row) < FULL_ROWS)  ? '1 :
                     (32'(s1_row) == FULL_ROWS) ? TAIL_MASK : '0;
  assign free_mask = ~row_rd_r & row_mask;

  always_comb begin
    free_bit = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (free_mask[b]) begin
        free_bit = ROW_BIT_W'(b);
      end
    end
  end

  assign cr_idx = {s1_row, free_bit};

  assign tick_sum = {1'b0, tok} + {1'b0, data_rd_r.rate};
  assign tick_new = (tick_sum > {1'b0, data_rd_r.burst}) ? data_rd_r.burst
                                                          : tick_sum[AMT_W-1:0];

  assign ret_sum = {1'b0, tok} + {1'b0, req_r.amount};
  assign ret_new = (ret_sum > {1'b0, data_rd_r.burst}) ? data_rd_r.burst
                                                        : ret_sum[AMT_W-1:0];
  assign fetch_n = (req_r.amount < tok) ? req_r.amount : tok;

  assign slot_ok = (32'(req_r.slot) < NUM_BKT_U) && bit_in_use;

  // fetch / return / destroy
  always_comb begin
    sg_status  = ST_OK;
    sg_granted = '0;
    sg_left    = '0;
    sg_tokens  = tok;
    sg_data_we = 1'b0;
    sg_row_we  = 1'b0;
    unique case (req_r.kind)
      KIND_FETCH: begin
        if (req_r.amount == '0) begin
          sg_status = ST_BAD_SIZE;
        end else if (!slot_ok) begin
          sg_status = ST_UNUSED;
        end else if (tok == '0) begin
          sg_status = ST_NO_TOKENS;
        end else begin
          sg_granted = fetch_n;
          sg_tokens  = tok - fetch_n;
          sg_left    = tok - fetch_n;
          sg_data_we = 1'b1;
        end
      end
      KIND_RETURN: begin
        if (req_r.amount == '0) begin
          sg_status = ST_BAD_SIZE;
        end else if (!slot_ok) begin
          sg_status = ST_UNUSED;
        end else begin
          sg_granted = req_r.amount;
          sg_tokens  = ret_new;
          sg_left    = ret_new;
          sg_data_we = 1'b1;
        end
      end
      KIND_DESTROY: begin
        if (!slot_ok) begin
          sg_status = ST_UNUSED;
        end else begin
          sg_row_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    data_we    = 1'b0;
    data_waddr = s1_idx_r;
    data_wdata = data_rd_r;
    if (cmd.cr_wr) begin
      data_we           = 1'b1;
      data_waddr        = cr_idx;
      data_wdata.rate   = req_r.fill_rate;
      data_wdata.burst  = req_r.burst_limit;
      data_wdata.tokens = '0;
    end else if (cmd.tick_wr && bit_in_use) begin
      data_we           = 1'b1;
      data_wdata.tokens = tick_new;
    end else if (cmd.sg_wr && sg_data_we) begin
      data_we           = 1'b1;
      data_wdata.tokens = sg_tokens;
    end
  end

  always_comb begin
    row_we    = 1'b0;
    row_waddr = s1_row;
    row_wdata = row_rd_r;
    if (cmd.clr_wr) begin
      row_we    = 1'b1;
      row_waddr = cnt_r[IDX_W-1:ROW_BIT_W];
      row_wdata = '0;
    end else if (cmd.cr_wr) begin
      row_we    = 1'b1;
      row_wdata = row_rd_r | (ROW_W'(1) << free_bit);
    end else if (cmd.sg_wr && sg_row_we) begin
      row_we    = 1'b1;
      row_wdata = row_rd_r & ~(ROW_W'(1) << s1_bit);
    end
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
  end

  always_comb begin
    res_val = '0;
    case (cmd.res_sel)
      RES_CREATE: begin
        res_val.status   = ST_OK;
        res_val.slot_out = SLOT_W'(cr_idx);
      end
      RES_FULL: begin
        res_val.status = ST_FULL;
      end
      RES_SINGLE: begin
        res_val.status      = sg_status;
        res_val.slot_out    = req_r.slot;
        res_val.granted     = sg_granted;
        res_val.tokens_left = sg_left;
      end
      RES_TICK: begin
        res_val.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      out_data_r <= res_val;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.out_free     = !out_valid_r || out_ready;
  assign sts.row_free     = |free_mask;
  assign sts.last_row     = &s1_row;
  assign sts.last_slot    = &s1_idx_r;
  assign sts.cnt_last_row = &cnt_r[IDX_W-1:ROW_BIT_W];

  // a new result never overwrites one still waiting
  a_res_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_ld |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  // create only claims a slot that is free and inside the table
  a_cr_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cr_wr |-> (free_mask != '0))
    else $error("create without free slot");

endmodule

@@ rtl/core/multi_token_bucket_table_unit.sv @@
// Channel | Dir | Handshake            | Payload
// in      | in  | in_valid / in_ready  | in_data  (in_t: kind, slot, amount, fill_rate, burst_limit)
// out     | out | out_valid / out_ready| out_data (out_t: status, slot_out, granted, tokens_left)
//
// Fetch, return and destroy: accept with table read, then write-back.
// Create: scans bitmap rows (32 slots each) from row 0 up to the one that holds the lowest free slot;
//   the scan reads one bitmap row per cycle from the row memory.
// Tick: walks all D slots, D = NUM_BUCKETS rounded up to a power of two (at least 64);
//   the walk reads one bucket per cycle and writes it back the next.
// After reset the in-use bitmap is cleared one row a cycle (ceil(NUM_BUCKETS/32) rows
//   rounded up to a power of two, at least 2, 32 rows at the default) before in_ready rises.
// A result waiting in the output register holds the final step of the next transaction.
module multi_token_bucket_table_unit import mtbt_pkg::*; #(
  parameter int NUM_BUCKETS = DEF_NUM_BUCKETS  // 1 .. 1024
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // controller sequences walks and write-backs; datapath owns the tables
  dp_cmd_t cmd;
  dp_sts_t sts;

  mtbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // bucket entries {rate, burst, tokens} and the in-use bitmap live here,
  // along with the request register and the output register
  mtbt_dp #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
